// ===== design/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
// Holds the operation codes, the special pattern bytes and the cell control struct.
// No dependencies.
package wgm_pkg;

   // Field widths fixed by the request format.
   localparam int unsigned OP_W   = 2;
   localparam int unsigned IDX_W  = 5;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned LEN_W  = 6;

   // Default number of pattern cells.
   localparam int unsigned MAX_PATTERN_DEF = 32;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Operation codes; the fourth code is unused and ignored.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_TEXT  = 2'd1;
   localparam logic [OP_W-1:0] OP_END   = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   // Special pattern bytes.
   localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic              text_step;
      logic              text_end;
      logic [CHAR_W-1:0] text_char;
      logic [CHAR_W-1:0] wr_char;
   } wgm_cell_ctrl_type;

endpackage

// ===== design/wgm_channels.sv =====
// Valid/ready channel interfaces for the request and the result side.
// Depends on wgm_pkg for the field widths.
interface wgm_req_if;
   logic                       valid;
   logic                       ready;
   logic [wgm_pkg::OP_W-1:0]   op;
   logic [wgm_pkg::IDX_W-1:0]  pattern_index;
   logic [wgm_pkg::CHAR_W-1:0] pattern_char;
   logic [wgm_pkg::CHAR_W-1:0] text_char;

   modport source (output valid, output op, output pattern_index, output pattern_char,
                   output text_char, input ready);
   modport sink   (input valid, input op, input pattern_index, input pattern_char,
                   input text_char, output ready);
endinterface

interface wgm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink   (input valid, input matched, output ready);
endinterface

// ===== design/wgm_closure.sv =====
// Star closure over the active position vector of the matcher.
// Lets every reachable star also be skipped, as a carry chain built from one add.
// Depends on nothing but its parameter.
module wgm_closure #(
   parameter int unsigned WIDTH = 33
) (
   input  logic [WIDTH-1:0] active,
   input  logic [WIDTH-1:0] prop,
   output logic [WIDTH-1:0] closed
);

   logic [WIDTH-1:0] gen;
   logic [WIDTH-1:0] sum;
   logic [WIDTH-1:0] carry;

   // A set position on a live star generates a carry that runs through
   // consecutive live stars; the carry into each bit marks a reachable position.
   always_comb begin
      gen    = active & prop;
      sum    = gen + prop;
      carry  = sum ^ gen ^ prop;
      closed = active | carry;
   end

endmodule

// ===== design/wgm_cell.sv =====
// One pattern cell: holds a pattern byte and the active bit of its position.
// Hands a match bit to its right neighbour on every text request.
// Depends on wgm_pkg.
module wgm_cell #(
   parameter logic RESET_ACTIVE = 1'b0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wgm_pkg::wgm_cell_ctrl_type ctrl,
   input  logic                       wr_en,
   input  logic                       live,
   input  logic                       closed_in,
   input  logic                       hand_in,
   output logic                       hand_out,
   output logic                       active_out,
   output logic                       prop_out
);

   logic [wgm_pkg::CHAR_W-1:0] byte_ff;
   logic [wgm_pkg::CHAR_W-1:0] byte_in;
   logic                       active_ff;
   logic                       active_in;
   logic                       is_star;
   logic                       char_hit;

   // Decode the stored byte.
   always_comb begin
      is_star  = (byte_ff == wgm_pkg::STAR_BYTE);
      char_hit = (byte_ff == wgm_pkg::ANY_BYTE) || (byte_ff == ctrl.text_char);
   end

   // A star keeps its position active; any other byte advances on a hit.
   assign prop_out   = is_star & live;
   assign hand_out   = closed_in & live & ~is_star & char_hit;
   assign active_out = active_ff;

   // Next position bit and byte store update.
   always_comb begin
      byte_in   = byte_ff;
      active_in = active_ff;
      if (wr_en) begin
         byte_in = ctrl.wr_char;
      end
      if (ctrl.text_step) begin
         active_in = (closed_in & is_star & live) | hand_in;
      end else if (ctrl.text_end) begin
         active_in = RESET_ACTIVE;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         active_ff <= RESET_ACTIVE;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

// ===== design/wildcard_glob_matcher.sv =====
// Whole-string glob matcher: '*' matches any run, '?' any single byte. It takes one
// request per clock cycle of every kind while ready is high, with no gaps between
// text bytes; the whole position update (star closure, compare in every cell,
// hand-off to the neighbour) completes within that cycle in the row of cells. An end
// request's result is registered into a two-entry output buffer, and ready falls
// only while both entries hold results not yet taken. No clearing pass follows reset;
// pattern entries that were never written read as undefined. Depends on wgm_pkg, the
// channel interfaces, wgm_cell and wgm_closure.
module wildcard_glob_matcher #(
   parameter int unsigned MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   wgm_req_if.sink                             req_chan,
   wgm_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wgm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wgm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wgm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned POS_N  = MAX_PATTERN + 1;
   localparam int unsigned USED_W = $clog2(MAX_PATTERN + 1);

   logic [wgm_pkg::LEN_W-1:0]  len_ff;
   logic [wgm_pkg::LEN_W-1:0]  len_in;
   logic [USED_W-1:0]          len_used;
   logic                       req_fire;
   logic                       wr_fire;
   logic                       end_fire;
   wgm_pkg::wgm_cell_ctrl_type ctrl;
   logic [MAX_PATTERN-1:0]     wr_en;
   logic [MAX_PATTERN-1:0]     live;
   logic [MAX_PATTERN-1:0]     cell_active;
   logic [MAX_PATTERN-1:0]     cell_prop;
   logic [MAX_PATTERN:0]       hand_chain;
   logic [POS_N-1:0]           active_vec;
   logic [POS_N-1:0]           prop_vec;
   logic [POS_N-1:0]           closed_vec;
   logic                       end_ff;
   logic                       end_in;
   logic                       head_valid_ff;
   logic                       head_valid_in;
   logic                       head_match_ff;
   logic                       head_match_in;
   logic                       tail_valid_ff;
   logic                       tail_valid_in;
   logic                       tail_match_ff;
   logic                       tail_match_in;
   logic                       new_match;
   logic                       pop;

   // Configuration register: pattern length at register zero.
   assign csr_pready = 1'b1;
   always_comb begin
      len_in = len_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         len_in = csr_pwdata[wgm_pkg::LEN_W-1:0];
      end
      if (csr_paddr[2]) begin
         csr_prdata = '0;
      end else begin
         csr_prdata = {{(wgm_pkg::CSR_DATA_W - wgm_pkg::LEN_W){1'b0}}, len_ff};
      end
   end

   // Length in use, saturated to the number of cells.
   always_comb begin
      if (32'(len_ff) > MAX_PATTERN) begin
         len_used = USED_W'(MAX_PATTERN);
      end else begin
         len_used = USED_W'(len_ff);
      end
   end

   // Request decode and broadcast to the cells.
   assign req_chan.ready = ~tail_valid_ff;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign wr_fire        = req_fire && (req_chan.op == wgm_pkg::OP_WRITE);
   assign end_fire       = req_fire && (req_chan.op == wgm_pkg::OP_END);
   always_comb begin
      ctrl.text_step = req_fire && (req_chan.op == wgm_pkg::OP_TEXT);
      ctrl.text_end  = end_fire;
      ctrl.text_char = req_chan.text_char;
      ctrl.wr_char   = req_chan.pattern_char;
   end

   // Row of pattern cells; each hands its match bit to the next.
   assign hand_chain[0] = 1'b0;
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      assign wr_en[k] = wr_fire && (32'(req_chan.pattern_index) == k);
      assign live[k]  = (32'(len_ff) > k);
      wgm_cell #(
         .RESET_ACTIVE((k == 0) ? 1'b1 : 1'b0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_en      (wr_en[k]),
         .live       (live[k]),
         .closed_in  (closed_vec[k]),
         .hand_in    (hand_chain[k]),
         .hand_out   (hand_chain[k+1]),
         .active_out (cell_active[k]),
         .prop_out   (cell_prop[k])
      );
   end

   // Star closure over all positions; the final position never propagates.
   assign active_vec = {end_ff, cell_active};
   assign prop_vec   = {1'b0, cell_prop};
   wgm_closure #(
      .WIDTH(POS_N)
   ) u_closure (
      .active (active_vec),
      .prop   (prop_vec),
      .closed (closed_vec)
   );

   // Position past the last cell.
   always_comb begin
      end_in = end_ff;
      if (ctrl.text_step) begin
         end_in = hand_chain[MAX_PATTERN];
      end else if (end_fire) begin
         end_in = 1'b0;
      end
   end

   // Two-entry result buffer: the head drives the result channel.
   assign new_match        = closed_vec[len_used];
   assign pop              = head_valid_ff & rsp_chan.ready;
   assign rsp_chan.valid   = head_valid_ff;
   assign rsp_chan.matched = head_match_ff;
   always_comb begin
      head_valid_in = head_valid_ff;
      head_match_in = head_match_ff;
      tail_valid_in = tail_valid_ff;
      tail_match_in = tail_match_ff;
      if (!head_valid_ff) begin
         head_valid_in = end_fire;
         head_match_in = new_match;
      end else if (pop) begin
         if (tail_valid_ff) begin
            head_match_in = tail_match_ff;
            tail_valid_in = end_fire;
            tail_match_in = new_match;
         end else begin
            head_valid_in = end_fire;
            head_match_in = new_match;
         end
      end else if (end_fire) begin
         tail_valid_in = 1'b1;
         tail_match_in = new_match;
      end
   end

   always_ff @(posedge clock) begin
      head_match_ff <= head_match_in;
      tail_match_ff <= tail_match_in;
      if (reset) begin
         len_ff        <= '0;
         end_ff        <= 1'b0;
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         end_ff        <= end_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   // An end request restarts the text with only position zero active.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> (active_vec == POS_N'(1)))
      else $error("position set not restarted after end request");

   // An end request always leaves a result on offer in the next cycle.
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> rsp_chan.valid)
      else $error("end request produced no result");

   // The second buffer entry is only ever filled behind the first.
   a_tail_behind_head: assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> head_valid_ff)
      else $error("result buffer tail valid without head");

   // The unused operation code leaves the position set untouched.
   a_unused_op_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.op == wgm_pkg::OP_NONE)) |=> $stable(active_vec))
      else $error("unused operation changed the position set");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard glob matcher: directed cases, then random
// patterns and texts under four idling phases. Depends on wgm_pkg, the channel
// interfaces and the wildcard_glob_matcher top level.
module tb;

   localparam int unsigned CELLS          = wgm_pkg::MAX_PATTERN_DEF;
   localparam int unsigned DRAIN_CYCLES   = 6;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam logic [wgm_pkg::CSR_ADDR_W-1:0] PATTERN_LENGTH_ADDR = '0;
   localparam logic [wgm_pkg::CHAR_W-1:0] CHAR_A = 8'h61;
   localparam logic [wgm_pkg::CHAR_W-1:0] CHAR_B = 8'h62;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [wgm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [wgm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [wgm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   wgm_req_if req_chan ();
   wgm_rsp_if rsp_chan ();

   wildcard_glob_matcher uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Our own copy of the matcher state.
   logic [wgm_pkg::CHAR_W-1:0] model_pattern [CELLS];
   logic [CELLS:0]             model_active;
   logic [wgm_pkg::LEN_W-1:0]  model_length;

   bit          expected_matches [$];
   int unsigned fail_count;
   int unsigned requests_sent;
   int unsigned results_seen;
   int unsigned matches_seen;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mark every position reachable through a star as also reachable past it.
   function automatic logic [CELLS:0] close_over_stars(logic [CELLS:0] set, int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
         if (set[k] && model_pattern[k] == wgm_pkg::STAR_BYTE) set[k+1] = 1'b1;
      end
      return set;
   endfunction

   // Advance the matched-prefix positions for one accepted request.
   function automatic void track_match_positions(logic [wgm_pkg::OP_W-1:0] op,
                                                 logic [wgm_pkg::IDX_W-1:0] idx,
                                                 logic [wgm_pkg::CHAR_W-1:0] pch,
                                                 logic [wgm_pkg::CHAR_W-1:0] tch);
      logic [CELLS:0] cur;
      logic [CELLS:0] nxt;
      int unsigned    len;
      len = (model_length > CELLS) ? CELLS : model_length;
      unique case (op)
         wgm_pkg::OP_WRITE: begin
            model_pattern[idx] = pch;
         end
         wgm_pkg::OP_TEXT: begin
            cur = close_over_stars(model_active, len);
            nxt = '0;
            for (int unsigned k = 0; k < len; k++) begin
               if (cur[k]) begin
                  if (model_pattern[k] == wgm_pkg::STAR_BYTE) nxt[k] = 1'b1;
                  else if (model_pattern[k] == wgm_pkg::ANY_BYTE || model_pattern[k] == tch)
                     nxt[k+1] = 1'b1;
               end
            end
            model_active = nxt;
         end
         wgm_pkg::OP_END: begin
            cur = close_over_stars(model_active, len);
            expected_matches = {expected_matches, bit'(cur[len])};
            model_active = {{CELLS{1'b0}}, 1'b1};
         end
         default: begin
         end
      endcase
   endfunction

   // Drive one request at the falling edge and hold it until it is accepted.
   task automatic send_request(input logic [wgm_pkg::OP_W-1:0] op,
                               input logic [wgm_pkg::IDX_W-1:0] idx,
                               input logic [wgm_pkg::CHAR_W-1:0] pch,
                               input logic [wgm_pkg::CHAR_W-1:0] tch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.op            <= op;
      req_chan.pattern_index <= idx;
      req_chan.pattern_char  <= pch;
      req_chan.text_char     <= tch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      track_match_positions(op, idx, pch, tch);
      if (op != wgm_pkg::OP_NONE) requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_entry(input logic [wgm_pkg::IDX_W-1:0] idx,
                              input logic [wgm_pkg::CHAR_W-1:0] ch);
      send_request(wgm_pkg::OP_WRITE, idx, ch, wgm_pkg::CHAR_W'($urandom_range(255)));
   endtask

   task automatic send_text(input logic [wgm_pkg::CHAR_W-1:0] ch);
      send_request(wgm_pkg::OP_TEXT, wgm_pkg::IDX_W'($urandom_range(31)),
                   wgm_pkg::CHAR_W'($urandom_range(255)), ch);
   endtask

   task automatic end_text();
      send_request(wgm_pkg::OP_END, wgm_pkg::IDX_W'($urandom_range(31)),
                   wgm_pkg::CHAR_W'($urandom_range(255)),
                   wgm_pkg::CHAR_W'($urandom_range(255)));
   endtask

   // Stop sending, let every expected result arrive, then allow the pipeline to settle.
   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      while (expected_matches.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the pattern length register through the configuration port.
   task automatic set_pattern_length(input int unsigned len);
      wait_for_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PATTERN_LENGTH_ADDR;
      csr_pwdata  <= wgm_pkg::CSR_DATA_W'(len);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      model_length = wgm_pkg::LEN_W'(len);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [wgm_pkg::CHAR_W-1:0] pick_pattern_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return wgm_pkg::STAR_BYTE;
      if (r < 55) return wgm_pkg::ANY_BYTE;
      if (r < 75) return CHAR_A;
      if (r < 95) return CHAR_B;
      return wgm_pkg::CHAR_W'($urandom_range(255));
   endfunction

   function automatic logic [wgm_pkg::CHAR_W-1:0] pick_text_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return CHAR_A;
      if (r < 80) return CHAR_B;
      return wgm_pkg::CHAR_W'($urandom_range(255));
   endfunction

   // Fill the whole store so that no unwritten entry is ever read. The layout puts the
   // lowest and highest bytes at the two ends with a run of stars in between.
   task automatic test_preload_store();
      write_entry(wgm_pkg::IDX_W'(0), 8'h00);
      for (int unsigned i = 1; i < CELLS - 1; i++)
         write_entry(wgm_pkg::IDX_W'(i), wgm_pkg::STAR_BYTE);
      write_entry(wgm_pkg::IDX_W'(CELLS - 1), 8'hFF);
   endtask

   // Full-length and saturated pattern lengths, and the empty pattern.
   task automatic test_length_extremes();
      set_pattern_length(63);
      send_text(8'h00);
      send_text(8'hFF);
      end_text();
      send_text(8'h00);
      end_text();
      end_text();
      set_pattern_length(CELLS);
      send_text(8'h00);
      send_text(CHAR_A);
      send_text(8'hFF);
      end_text();
      set_pattern_length(0);
      end_text();
      send_text(CHAR_B);
      end_text();
   endtask

   // An all-star pattern matches the empty text; a single-byte wildcard needs one byte.
   task automatic test_stars_and_any();
      write_entry(wgm_pkg::IDX_W'(0), wgm_pkg::STAR_BYTE);
      set_pattern_length(3);
      end_text();
      send_text(8'h7A);
      end_text();
      write_entry(wgm_pkg::IDX_W'(0), wgm_pkg::ANY_BYTE);
      write_entry(wgm_pkg::IDX_W'(1), CHAR_B);
      set_pattern_length(2);
      send_text(8'h78);
      send_text(CHAR_B);
      end_text();
   endtask

   // The unused operation must leave the state alone, and an edit during a text must
   // take effect at once.
   task automatic test_ignored_op_and_edit();
      send_text(8'h78);
      send_request(wgm_pkg::OP_NONE, wgm_pkg::IDX_W'(1), 8'h2A, CHAR_A);
      send_text(CHAR_B);
      end_text();
      send_text(CHAR_A);
      write_entry(wgm_pkg::IDX_W'(1), 8'h63);
      send_text(8'h63);
      end_text();
   endtask

   // One random pattern, configured while idle, followed by a few texts built from it.
   task automatic random_pattern_group();
      logic [wgm_pkg::CHAR_W-1:0] text_q [$];
      logic [wgm_pkg::CHAR_W-1:0] c;
      int unsigned                len;
      int unsigned                cells;
      int unsigned                r;
      int unsigned                texts;
      r = $urandom_range(99);
      if (r < 90) len = $urandom_range(0, 8);
      else if (r < 95) len = CELLS;
      else len = $urandom_range(CELLS + 1, 63);
      cells = (len > CELLS) ? CELLS : len;
      for (int unsigned i = 0; i < cells; i++)
         write_entry(wgm_pkg::IDX_W'(i), pick_pattern_byte());
      set_pattern_length(len);
      texts = $urandom_range(1, 4);
      repeat (texts) begin
         text_q.delete();
         for (int unsigned k = 0; k < cells; k++) begin
            c = model_pattern[k];
            if (c == wgm_pkg::STAR_BYTE) begin
               repeat ($urandom_range(0, 3)) text_q = {text_q, pick_text_byte()};
            end else if (c == wgm_pkg::ANY_BYTE) begin
               text_q = {text_q, wgm_pkg::CHAR_W'($urandom_range(255))};
            end else begin
               text_q = {text_q, c};
            end
         end
         // Break some of the texts so that mismatches are common too.
         r = $urandom_range(99);
         if (r < 12 && text_q.size() != 0) text_q[$urandom_range(text_q.size() - 1)] =
            pick_text_byte();
         else if (r < 20 && text_q.size() != 0) void'(text_q.pop_back());
         else if (r < 28) text_q = {text_q, pick_text_byte()};
         foreach (text_q[i]) begin
            r = $urandom_range(99);
            if (r < 4) send_request(wgm_pkg::OP_NONE, wgm_pkg::IDX_W'($urandom_range(31)),
                                    wgm_pkg::CHAR_W'($urandom_range(255)),
                                    wgm_pkg::CHAR_W'($urandom_range(255)));
            else if (r < 7)
               write_entry(wgm_pkg::IDX_W'($urandom_range(31)), pick_pattern_byte());
            send_text(text_q[i]);
         end
         end_text();
      end
   endtask

   task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned quota);
      int unsigned stop_at;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = requests_sent + quota;
      while (requests_sent < stop_at) random_pattern_group();
   endtask

   // Result side: stall at random and compare each result with the oldest expectation.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.matched === 1'b1) matches_seen++;
         if (expected_matches.size() == 0) begin
            $error("matched: result arrived with nothing expected, actual %0b",
                   rsp_chan.matched);
            fail_count++;
         end else if (rsp_chan.matched !== expected_matches[0]) begin
            $error("matched: expected %0b, actual %0b", expected_matches[0], rsp_chan.matched);
            fail_count++;
            void'(expected_matches.pop_front());
         end else begin
            void'(expected_matches.pop_front());
         end
      end
   end

   // Watchdog: end the run if nothing is accepted for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_psel && csr_penable && csr_pready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Main sequence.
   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.op            = wgm_pkg::OP_NONE;
      req_chan.pattern_index = '0;
      req_chan.pattern_char  = '0;
      req_chan.text_char     = '0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      model_active           = {{CELLS{1'b0}}, 1'b1};
      model_length           = '0;
      fail_count             = 0;
      requests_sent          = 0;
      results_seen           = 0;
      matches_seen           = 0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      foreach (model_pattern[i]) model_pattern[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_preload_store();
      test_length_extremes();
      test_stars_and_any();
      test_ignored_op_and_edit();
      test_random_phase(0, 0, 220);
      test_random_phase(74, 0, 220);
      test_random_phase(0, 74, 220);
      test_random_phase(18, 18, 220);
      wait_for_idle();

      $display("Covered %0d requests and %0d results (%0d matches) across directed cases",
               requests_sent, results_seen, matches_seen);
      $display("and random patterns under four idling phases.");
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/wgm_pkg.sv
design/wgm_channels.sv
design/wgm_closure.sv
design/wgm_cell.sv
design/wildcard_glob_matcher.sv
test/tb.sv
